// ===== rtl/scb_pkg.sv =====
// Shared types and codes for the structured control edge builder.
// No dependencies; compiled first.
package scb_pkg;

    typedef enum logic [3:0] {
        C_PLAIN,
        C_BLOCK,
        C_LOOP,
        C_IF,
        C_ELSE,
        C_END,
        C_RET,
        C_BR,
        C_BRIF,
        C_BRTAB,
        C_START
    } t_op_class;

    typedef struct packed {
        t_op_class  cls;
        logic [5:0] depth;
    } t_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } t_state;

    localparam logic [3:0] OP_PLAIN  = 4'd0;
    localparam logic [3:0] OP_BLOCK  = 4'd1;
    localparam logic [3:0] OP_LOOP   = 4'd2;
    localparam logic [3:0] OP_IF     = 4'd3;
    localparam logic [3:0] OP_ELSE   = 4'd4;
    localparam logic [3:0] OP_END    = 4'd5;
    localparam logic [3:0] OP_RET    = 4'd6;
    localparam logic [3:0] OP_BR     = 4'd7;
    localparam logic [3:0] OP_BRIF   = 4'd8;
    localparam logic [3:0] OP_BRTAB  = 4'd9;
    localparam logic [3:0] OP_START  = 4'd10;

    localparam logic [1:0] REC_EDGE  = 2'd0;
    localparam logic [1:0] REC_PLACE = 2'd1;
    localparam logic [1:0] REC_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BRTAB    = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW = 3'd2;
    localparam logic [2:0] ERR_UNDERFL  = 3'd3;
    localparam logic [2:0] ERR_ELSE     = 3'd4;
    localparam logic [2:0] ERR_LIMIT    = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] from_block;
        logic [15:0] to_block;
        logic [2:0]  error_code;
    } t_record;

endpackage

// ===== rtl/scb_if.sv =====
// Handshake channels of the edge builder: opcode input and record output.
// Depends on nothing.
interface scb_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] operation;
    logic [5:0] label_depth;

    modport source (output valid, output operation, output label_depth, input ready);
    modport sink   (input valid, input operation, input label_depth, output ready);
endinterface

interface scb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [15:0] from_block;
    logic [15:0] to_block;
    logic [2:0]  error_code;
    logic        last_record;

    modport source (output valid, output record_kind, output from_block, output to_block,
                     output error_code, output last_record, input ready);
    modport sink   (input valid, input record_kind, input from_block, input to_block,
                    input error_code, input last_record, output ready);
endinterface

// ===== rtl/scb_front.sv =====
// Front end: accepts opcode words, classifies them and queues them.
// Depends on scb_pkg and scb_in_if.
module scb_front
    import scb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    scb_in_if.sink   i_in,
    output logic     o_q_valid,
    output t_item    o_q_item,
    input  logic     i_q_pop
);

    t_item       r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    t_item       cls_item;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rp];

    always_comb begin
        cls_item.depth = i_in.label_depth;
        unique case (i_in.operation)
            OP_BLOCK: cls_item.cls = C_BLOCK;
            OP_LOOP:  cls_item.cls = C_LOOP;
            OP_IF:    cls_item.cls = C_IF;
            OP_ELSE:  cls_item.cls = C_ELSE;
            OP_END:   cls_item.cls = C_END;
            OP_RET:   cls_item.cls = C_RET;
            OP_BR:    cls_item.cls = C_BR;
            OP_BRIF:  cls_item.cls = C_BRIF;
            OP_BRTAB: cls_item.cls = C_BRTAB;
            OP_START: cls_item.cls = C_START;
            default:  cls_item.cls = C_PLAIN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

// ===== rtl/scb_back.sv =====
// Back end: frame stack memory, block allocator and record emission.
// Depends on scb_pkg and scb_out_if.
module scb_back
    import scb_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int BLOCK_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_item     i_q_item,
    output logic      o_q_pop,
    scb_out_if.source o_out
);

    localparam int HW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);
    localparam int CW = (HW > 6) ? HW : 6;
    localparam logic [BLOCK_BITS:0] LIMIT = {1'b0, {BLOCK_BITS{1'b1}}};

    typedef struct packed {
        logic [BLOCK_BITS-1:0] br_t;
        logic [BLOCK_BITS-1:0] end_t;
        logic [BLOCK_BITS-1:0] pred;
        logic                  is_if;
        logic                  has_else;
    } t_frame;

    localparam t_frame FRAME0_INIT = '{br_t: BLOCK_BITS'(1), end_t: BLOCK_BITS'(1),
                                      pred: '0, is_if: 1'b0, has_else: 1'b0};

    // Frame 0 lives in flip-flops so that a function start can restore it.
    t_frame                r_mem [STACK_DEPTH];
    t_frame                r_frame0;
    t_frame                r_rd_frame;
    logic                  r_fzero;
    t_state                r_state, n_state;
    t_item                 r_item;
    logic [BLOCK_BITS-1:0] r_next, n_next;
    logic [BLOCK_BITS-1:0] r_cur, n_cur;
    logic [HW-1:0]         r_height, n_height;
    t_record               r_rec [3];
    t_record               n_rec [3];
    logic [1:0]            r_cnt, n_cnt;
    logic [1:0]            r_idx;

    logic                  fetch;
    logic [HW-1:0]         rd_full;
    t_frame                f;
    logic                  can1, can2, depth_bad;
    logic [BLOCK_BITS-1:0] t_blk, nx_blk;
    logic                  wr_en;
    logic [HW-1:0]         wr_idx;
    t_frame                wr_frame;
    logic                  reset_state;

    assign fetch   = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop = fetch;

    always_comb begin
        if (i_q_item.cls == C_BR || i_q_item.cls == C_BRIF) begin
            rd_full = r_height - HW'(1) - HW'(i_q_item.depth);
        end else begin
            rd_full = r_height - HW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fetch) begin
            r_item     <= i_q_item;
            r_rd_frame <= r_mem[rd_full[IW-1:0]];
            r_fzero    <= (rd_full == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && wr_en && wr_idx != '0) begin
            r_mem[wr_idx[IW-1:0]] <= wr_frame;
        end
    end

    assign f         = r_fzero ? r_frame0 : r_rd_frame;
    assign can1      = ({1'b0, r_next} + (BLOCK_BITS+1)'(1)) <= LIMIT;
    assign can2      = ({1'b0, r_next} + (BLOCK_BITS+1)'(2)) <= LIMIT;
    assign t_blk     = r_next + BLOCK_BITS'(1);
    assign nx_blk    = r_next + BLOCK_BITS'(2);
    assign depth_bad = CW'(r_item.depth) >= CW'(r_height);

    function automatic t_record mk(input logic [1:0] kind, input logic [BLOCK_BITS-1:0] from,
                                   input logic [BLOCK_BITS-1:0] to, input logic [2:0] err);
        t_record r;
        r.kind       = kind;
        r.from_block = 16'(from);
        r.to_block   = 16'(to);
        r.error_code = err;
        return r;
    endfunction

    // Executes the held item against the fetched frame.
    always_comb begin
        n_next      = r_next;
        n_cur       = r_cur;
        n_height    = r_height;
        n_cnt       = 2'd1;
        n_rec[0]    = mk(REC_PLACE, r_cur, '0, ERR_NONE);
        n_rec[1]    = n_rec[0];
        n_rec[2]    = n_rec[0];
        wr_en       = 1'b0;
        wr_idx      = r_height;
        wr_frame    = f;
        reset_state = 1'b0;
        unique case (r_item.cls)
            C_BLOCK, C_LOOP, C_IF: begin
                if (CW'(r_height) >= CW'(STACK_DEPTH)) begin
                    n_rec[0] = mk(REC_ERROR, r_cur, '0, ERR_OVERFLOW);
                end else if (!can2) begin
                    n_rec[0] = mk(REC_ERROR, r_cur, '0, ERR_LIMIT);
                end else begin
                    n_rec[0] = mk(REC_EDGE, r_cur, t_blk, ERR_NONE);
                    n_rec[1] = mk(REC_PLACE, r_cur, '0, ERR_NONE);
                    n_cnt    = (r_item.cls == C_IF) ? 2'd2 : 2'd1;
                    wr_en    = 1'b1;
                    wr_frame.br_t     = (r_item.cls == C_LOOP) ? t_blk : nx_blk;
                    wr_frame.end_t    = nx_blk;
                    wr_frame.pred     = r_cur;
                    wr_frame.is_if    = (r_item.cls == C_IF);
                    wr_frame.has_else = 1'b0;
                    n_height = r_height + HW'(1);
                    n_cur    = t_blk;
                    n_next   = nx_blk;
                end
            end
            C_ELSE: begin
                if (r_height == '0 || !f.is_if || f.has_else) begin
                    n_rec[0] = mk(REC_ERROR, r_cur, '0, ERR_ELSE);
                end else if (!can1) begin
                    n_rec[0] = mk(REC_ERROR, r_cur, '0, ERR_LIMIT);
                end else begin
                    n_rec[0] = mk(REC_EDGE, r_cur, f.end_t, ERR_NONE);
                    n_rec[1] = mk(REC_EDGE, f.pred, t_blk, ERR_NONE);
                    n_cnt    = 2'd2;
                    wr_en    = 1'b1;
                    wr_idx   = r_height - HW'(1);
                    wr_frame.has_else = 1'b1;
                    n_cur    = t_blk;
                    n_next   = t_blk;
                end
            end
            C_END: begin
                if (r_height == '0) begin
                    n_rec[0] = mk(REC_ERROR, r_cur, '0, ERR_UNDERFL);
                end else begin
                    n_rec[0] = mk(REC_EDGE, r_cur, f.end_t, ERR_NONE);
                    n_rec[1] = mk(REC_EDGE, f.pred, f.end_t, ERR_NONE);
                    n_cnt    = (f.is_if && !f.has_else) ? 2'd2 : 2'd1;
                    n_cur    = f.end_t;
                    n_height = r_height - HW'(1);
                end
            end
            C_RET: begin
                if (r_height == '0) begin
                    n_rec[0] = mk(REC_ERROR, r_cur, '0, ERR_UNDERFL);
                end else if (!can1) begin
                    n_rec[0] = mk(REC_ERROR, r_cur, '0, ERR_LIMIT);
                end else begin
                    n_rec[0] = mk(REC_EDGE, r_cur, r_frame0.end_t, ERR_NONE);
                    n_rec[1] = mk(REC_PLACE, r_cur, '0, ERR_NONE);
                    n_cnt    = 2'd2;
                    n_cur    = t_blk;
                    n_next   = t_blk;
                end
            end
            C_BR, C_BRIF: begin
                if (depth_bad || !can1) begin
                    n_rec[0] = mk(REC_ERROR, r_cur, '0, ERR_LIMIT);
                end else if (r_item.cls == C_BRIF) begin
                    n_rec[0] = mk(REC_EDGE, r_cur, t_blk, ERR_NONE);
                    n_rec[1] = mk(REC_EDGE, r_cur, f.br_t, ERR_NONE);
                    n_rec[2] = mk(REC_PLACE, r_cur, '0, ERR_NONE);
                    n_cnt    = 2'd3;
                    n_cur    = t_blk;
                    n_next   = t_blk;
                end else begin
                    n_rec[0] = mk(REC_EDGE, r_cur, f.br_t, ERR_NONE);
                    n_rec[1] = mk(REC_PLACE, r_cur, '0, ERR_NONE);
                    n_cnt    = 2'd2;
                    n_cur    = t_blk;
                    n_next   = t_blk;
                end
            end
            C_BRTAB: begin
                n_rec[0] = mk(REC_ERROR, r_cur, '0, ERR_BRTAB);
            end
            C_START: begin
                n_cnt       = 2'd0;
                reset_state = 1'b1;
            end
            default: begin
                n_cnt = 2'd1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_q_valid) n_state = S_EXEC;
            S_EXEC: n_state = (n_cnt == 2'd0) ? S_IDLE : S_EMIT;
            S_EMIT: if (o_out.ready && r_idx == r_cnt - 2'd1) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_out.valid       = (r_state == S_EMIT);
        o_out.record_kind = r_rec[r_idx].kind;
        o_out.from_block  = r_rec[r_idx].from_block;
        o_out.to_block    = r_rec[r_idx].to_block;
        o_out.error_code  = r_rec[r_idx].error_code;
        o_out.last_record = (r_idx == r_cnt - 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_rec <= n_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_next   <= BLOCK_BITS'(1);
            r_cur    <= '0;
            r_height <= HW'(1);
            r_frame0 <= FRAME0_INIT;
            r_cnt    <= 2'd0;
            r_idx    <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_cnt <= n_cnt;
                r_idx <= 2'd0;
                if (reset_state) begin
                    r_next   <= BLOCK_BITS'(1);
                    r_cur    <= '0;
                    r_height <= HW'(1);
                    r_frame0 <= FRAME0_INIT;
                end else begin
                    r_next   <= n_next;
                    r_cur    <= n_cur;
                    r_height <= n_height;
                    if (wr_en && wr_idx == '0) begin
                        r_frame0 <= wr_frame;
                    end
                end
            end else if (r_state == S_EMIT && o_out.ready) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

// ===== rtl/structured_control_cfg_edge_builder.sv =====
// An opcode word passes through the queue, the frame memory read and the execute step
// and then emits its records, 0 to 3 of them, one at a time as the output takes them;
// the back end fetches no new word until every record of the previous one is taken.
// A two-word queue lets the input keep accepting while records drain.
// Reset is synchronous, active low: entry block current, exit frame on the stack.
// Top level; depends on scb_pkg, scb_if, scb_front and scb_back.
module structured_control_cfg_edge_builder
    import scb_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int BLOCK_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scb_in_if.sink    i_in_ch,
    scb_out_if.source o_out_ch
);

    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    scb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in_ch),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    scb_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .BLOCK_BITS  (BLOCK_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_out     (o_out_ch)
    );

endmodule

// ===== rtl/scb_checker.sv =====
// Port-level checks on the record output of the edge builder, bound to the top level.
// Depends on scb_pkg and structured_control_cfg_edge_builder.
module scb_checker
    import scb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic [15:0] i_to,
    input logic [2:0]  i_err,
    input logic        i_last
);

    // A stalled word keeps its kind, target and last flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_to) && $stable(i_last))
        else $error("output word changed while stalled");

    // An error record ends its opcode's records and carries a code.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == REC_ERROR |-> i_last && i_err != ERR_NONE)
        else $error("error record not final or without code");

    a_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == REC_PLACE |-> i_to == 16'd0 && i_err == ERR_NONE)
        else $error("placement record with target or code");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_kind == REC_EDGE || i_kind == REC_PLACE || i_kind == REC_ERROR)
        else $error("unknown record kind");

endmodule

bind structured_control_cfg_edge_builder scb_checker u_scb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out_ch.valid),
    .i_ready (o_out_ch.ready),
    .i_kind  (o_out_ch.record_kind),
    .i_to    (o_out_ch.to_block),
    .i_err   (o_out_ch.error_code),
    .i_last  (o_out_ch.last_record)
);
